/* rtl/pgd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_pkg: shared types, constants and functions
// Holds the Gold code generator constants, the LFSR step functions and the
// types that travel between the descrambler modules.
// ----------------------------------------------------------------------------
package pgd_pkg;

    localparam int LFSR_W           = 18;
    localparam int SEQ_W            = 5;
    localparam int CNT_W            = 19;
    localparam int POS_W            = 10;
    localparam int CFG_ADDR_W       = 1;
    localparam int CFG_DATA_W       = 5;
    localparam int SAMPLE_WIDTH_DEF = 16;

    typedef logic [LFSR_W-1:0] lfsr_t;

    localparam lfsr_t LFSR_ONES = '1;
    localparam lfsr_t LFSR_ONE  = lfsr_t'(1);

    // Code index n = seq * SEQ_STEP; the shifted branch runs SHIFT_OFFSET further.
    localparam logic [CNT_W-1:0] SEQ_STEP     = 19'd10949;
    localparam logic [CNT_W-1:0] SHIFT_OFFSET = 19'd131072;

    localparam logic [POS_W-1:0] HDR_NORMAL = 10'd90;
    localparam logic [POS_W-1:0] HDR_VLSNR  = 10'd990;
    localparam logic [POS_W-1:0] POS_MAX    = 10'd1023;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_SCRAMBLER_SEQ = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_VL_SNR_MODE   = 1'b1;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef struct packed {
        lfsr_t x_seed;
        lfsr_t x_shift_seed;
        lfsr_t y_shift_seed;
    } seeds_t;

    function automatic lfsr_t adv_x(input lfsr_t r);
        return {r[0] ^ r[7], r[LFSR_W-1:1]};
    endfunction

    function automatic lfsr_t adv_y(input lfsr_t r);
        return {r[0] ^ r[5] ^ r[7] ^ r[10], r[LFSR_W-1:1]};
    endfunction

endpackage

/* rtl/pgd_seed_gen.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_seed_gen: frame seed generator
// Holds the scrambling sequence number and walks the x and y LFSRs one step
// per cycle from their start values to capture the frame seeds.
// ----------------------------------------------------------------------------
module pgd_seed_gen (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           seq_wr,
    input  logic [pgd_pkg::SEQ_W-1:0]      seq_wdata,
    output logic                           busy,
    output pgd_pkg::seeds_t                seeds
);
    import pgd_pkg::*;

    logic [SEQ_W-1:0] seq_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    lfsr_t            xr_reg;
    lfsr_t            yr_reg;
    seeds_t           seeds_reg;

    logic [CNT_W-1:0] n_steps;
    logic [CNT_W-1:0] n_end;

    assign n_steps = {{(CNT_W-SEQ_W){1'b0}}, seq_reg} * SEQ_STEP;
    assign n_end   = n_steps + SHIFT_OFFSET;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg  <= '0;
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            xr_reg   <= LFSR_ONE;
            yr_reg   <= LFSR_ONES;
        end else if (seq_wr) begin
            seq_reg  <= seq_wdata;
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            xr_reg   <= LFSR_ONE;
            yr_reg   <= LFSR_ONES;
        end else if (busy_reg) begin
            xr_reg  <= adv_x(xr_reg);
            yr_reg  <= adv_y(yr_reg);
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == n_end) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The counter value equals the number of steps already taken.
    always_ff @(posedge aclk) begin
        if (busy_reg && !seq_wr) begin
            if (cnt_reg == n_steps) begin
                seeds_reg.x_seed <= xr_reg;
            end
            if (cnt_reg == n_end) begin
                seeds_reg.x_shift_seed <= xr_reg;
            end
            if (cnt_reg == SHIFT_OFFSET) begin
                seeds_reg.y_shift_seed <= yr_reg;
            end
        end
    end

    assign busy  = busy_reg;
    assign seeds = seeds_reg;

endmodule

/* rtl/pgd_code_gen.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_code_gen: Gold code and frame position tracker
// Keeps the four running LFSRs and the symbol position, and gives the
// rotation code for the word now at the input.
// ----------------------------------------------------------------------------
module pgd_code_gen (
    input  logic             aclk,
    input  logic             aresetn,
    input  pgd_pkg::seeds_t  seeds,
    input  logic             vl_snr_mode,
    input  logic             advance,
    input  logic             frame_end,
    output pgd_pkg::rot_t    rot
);
    import pgd_pkg::*;

    lfsr_t            x_reg, y_reg, xs_reg, ys_reg;
    lfsr_t            x_cur, y_cur, xs_cur, ys_cur;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] hdr_len;
    logic             frame_start;
    logic             scrambled;

    assign frame_start = (pos_reg == '0);
    assign x_cur  = frame_start ? seeds.x_seed       : x_reg;
    assign y_cur  = frame_start ? LFSR_ONES          : y_reg;
    assign xs_cur = frame_start ? seeds.x_shift_seed : xs_reg;
    assign ys_cur = frame_start ? seeds.y_shift_seed : ys_reg;

    assign hdr_len   = vl_snr_mode ? HDR_VLSNR : HDR_NORMAL;
    assign scrambled = (pos_reg >= hdr_len);

    assign rot = scrambled ? rot_t'({xs_cur[0] ^ ys_cur[0], x_cur[0] ^ y_cur[0]}) : ROT_0;

    always_comb begin
        if (frame_end) begin
            pos_next = '0;
        end else if (pos_reg != POS_MAX) begin
            pos_next = pos_reg + 1'b1;
        end else begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (advance) begin
            pos_reg <= pos_next;
        end
    end

    // The generators hold still through the header.
    always_ff @(posedge aclk) begin
        if (advance) begin
            x_reg  <= scrambled ? adv_x(x_cur)  : x_cur;
            y_reg  <= scrambled ? adv_y(y_cur)  : y_cur;
            xs_reg <= scrambled ? adv_x(xs_cur) : xs_cur;
            ys_reg <= scrambled ? adv_y(ys_cur) : ys_cur;
        end
    end

endmodule

/* rtl/pgd_rotator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_rotator: quarter-turn symbol rotator
// Rotates one complex sample by a multiple of 90 degrees, with the negation
// of the most negative value saturating to the largest positive value.
// ----------------------------------------------------------------------------
module pgd_rotator #(
    parameter int SAMPLE_WIDTH = pgd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic signed [SAMPLE_WIDTH-1:0] in_i,
    input  logic signed [SAMPLE_WIDTH-1:0] in_q,
    input  pgd_pkg::rot_t                  rot,
    output logic signed [SAMPLE_WIDTH-1:0] out_i,
    output logic signed [SAMPLE_WIDTH-1:0] out_q
);
    import pgd_pkg::*;

    localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    logic signed [SAMPLE_WIDTH-1:0] neg_i, neg_q;

    assign neg_i = (in_i == S_MIN) ? S_MAX : -in_i;
    assign neg_q = (in_q == S_MIN) ? S_MAX : -in_q;

    always_comb begin
        case (rot)
            ROT_90: begin
                out_i = in_q;
                out_q = neg_i;
            end
            ROT_180: begin
                out_i = neg_i;
                out_q = neg_q;
            end
            ROT_270: begin
                out_i = neg_q;
                out_q = in_i;
            end
            default: begin
                out_i = in_i;
                out_q = in_q;
            end
        endcase
    end

endmodule

/* rtl/pl_gold_descrambler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl_gold_descrambler_top: physical layer Gold code descrambler
// Passes the frame header through and rotates every later symbol by the
// quarter turn picked from a pair of Gold sequences.
//
//   Channel   Direction  Handshake         Payload
//   s_        in         tvalid / tready   tdata = {q, i}, tlast = frame end
//   m_        out        tvalid / tready   tdata = {q, i}, tlast = frame end
//   cfg_      in         cfg_we            cfg_addr, cfg_wdata
//
// One word per cycle while s_tready is high; a word appears on m_ in the
// cycle after it is accepted. After reset, and after each write of
// scrambler_seq, the seed generator steps its LFSRs once a cycle, with
// s_tready low, until it has captured the shifted x seed.
// A stalled output word holds s_tready low; the next input word can be
// taken in the same cycle as it leaves. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module pl_gold_descrambler_top #(
    parameter int SAMPLE_WIDTH = pgd_pkg::SAMPLE_WIDTH_DEF,
    localparam int TDATA_W     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [TDATA_W-1:0]              s_tdata,   // in_i, in_q
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [TDATA_W-1:0]              m_tdata,   // out_i, out_q
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [pgd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pgd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import pgd_pkg::*;

    logic                           seed_busy;
    seeds_t                         seeds;
    logic                           vl_snr_reg;
    logic                           in_accept;
    rot_t                           rot;
    logic signed [SAMPLE_WIDTH-1:0] in_i, in_q;
    logic signed [SAMPLE_WIDTH-1:0] rot_i, rot_q;
    logic                           m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_i_reg, out_q_reg;
    logic                           out_last_reg;

    assign in_i = s_tdata[SAMPLE_WIDTH-1:0];
    assign in_q = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

    assign s_tready  = !seed_busy && (!m_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_snr_reg <= 1'b0;
        end else if (cfg_we && cfg_addr == REG_VL_SNR_MODE) begin
            vl_snr_reg <= cfg_wdata[0];
        end
    end

    pgd_seed_gen u_seed_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seq_wr    (cfg_we && cfg_addr == REG_SCRAMBLER_SEQ),
        .seq_wdata (cfg_wdata[SEQ_W-1:0]),
        .busy      (seed_busy),
        .seeds     (seeds)
    );

    pgd_code_gen u_code_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .seeds       (seeds),
        .vl_snr_mode (vl_snr_reg),
        .advance     (in_accept),
        .frame_end   (s_tlast),
        .rot         (rot)
    );

    pgd_rotator #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_rotator (
        .in_i  (in_i),
        .in_q  (in_q),
        .rot   (rot),
        .out_i (rot_i),
        .out_q (rot_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_i_reg    <= rot_i;
            out_q_reg    <= rot_q;
            out_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({out_q_reg, out_i_reg});
    assign m_tlast  = out_last_reg;

endmodule

/* verif/pl_gold_descrambler_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl_gold_descrambler_top_test: self-checking bench for the Gold descrambler
// Streams framed I/Q words through the block and compares every output word
// with a bit-true predictor of the header bypass, the Gold code rotation and
// the saturating negation. Covers both header lengths, sequence numbers 0, 5
// and 31, frames shorter than the header, and settings changed inside a
// frame, with random gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module pl_gold_descrambler_top_test;
    import pgd_pkg::*;

    localparam int SW          = 16;
    localparam int TDATA_W     = 32;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int IDLE_PCT    = 34;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        sample_t q_val;
        sample_t i_val;
        logic    frame_end;
    } symbol_t;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam sample_t EDGE_VALS [4] = '{SAMPLE_MIN, SAMPLE_MAX, sample_t'(0), sample_t'(-1)};

    localparam logic [CFG_DATA_W-1:0] SEQ_FIRST  = 5'd0;
    localparam logic [CFG_DATA_W-1:0] SEQ_BEYOND = 5'd31;
    localparam logic [CFG_DATA_W-1:0] SEQ_MID    = 5'd5;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata   = '0;   // in_i, in_q
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;          // out_i, out_q
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = REG_SCRAMBLER_SEQ;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Predictor state.
    logic             vl_mode;
    lfsr_t            x_seed_r, xs_seed_r, ys_seed_r;
    lfsr_t            x_reg, y_reg, xs_reg, ys_reg;
    logic [POS_W-1:0] frame_pos;
    symbol_t          descrambled_q[$];

    int   fail_count   = 0;
    int   word_count   = 0;
    int   frame_count  = 0;
    int   cycle_count  = 0;
    int   rot_seen [4] = '{default: 0};
    logic gaps_on      = 1'b1;

    pl_gold_descrambler_top #(
        .SAMPLE_WIDTH (SW)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic lfsr_t gold_x_next(input lfsr_t r);
        lfsr_t fb;
        fb = lfsr_t'(r[0] ^ r[7]);
        return (r >> 1) | (fb << (LFSR_W - 1));
    endfunction

    function automatic lfsr_t gold_y_next(input lfsr_t r);
        lfsr_t fb;
        fb = lfsr_t'(r[0] ^ r[5] ^ r[7] ^ r[10]);
        return (r >> 1) | (fb << (LFSR_W - 1));
    endfunction

    // The x seed is the all-zero-but-one state walked n = seq * 10949 steps; the
    // shifted seed walks a further 2^17 steps. No clamp is applied above 23.
    function void load_seeds(input logic [SEQ_W-1:0] seq);
        int    n;
        int    k;
        lfsr_t r;
        n = int'(seq) * int'(SEQ_STEP);
        r = LFSR_ONE;
        for (k = 0; k < n; k++)
            r = gold_x_next(r);
        x_seed_r = r;
        for (k = 0; k < int'(SHIFT_OFFSET); k++)
            r = gold_x_next(r);
        xs_seed_r = r;
    endfunction

    function automatic sample_t negate_clip(input sample_t v);
        return (v == SAMPLE_MIN) ? SAMPLE_MAX : -v;
    endfunction

    function void predict_symbol(input sample_t si, input sample_t sq, input logic frame_end);
        symbol_t          w;
        rot_t             rot;
        logic [POS_W-1:0] hdr;
        hdr = vl_mode ? HDR_VLSNR : HDR_NORMAL;
        if (frame_pos == '0) begin
            x_reg  = x_seed_r;
            y_reg  = LFSR_ONES;
            xs_reg = xs_seed_r;
            ys_reg = ys_seed_r;
        end
        w.i_val     = si;
        w.q_val     = sq;
        w.frame_end = frame_end;
        // The generators only step on scrambled words, never in the header.
        if (frame_pos >= hdr) begin
            rot = rot_t'({xs_reg[0] ^ ys_reg[0], x_reg[0] ^ y_reg[0]});
            rot_seen[int'(rot)]++;
            case (rot)
                ROT_90: begin
                    w.i_val = sq;
                    w.q_val = negate_clip(si);
                end
                ROT_180: begin
                    w.i_val = negate_clip(si);
                    w.q_val = negate_clip(sq);
                end
                ROT_270: begin
                    w.i_val = negate_clip(sq);
                    w.q_val = si;
                end
                default: ;
            endcase
            x_reg  = gold_x_next(x_reg);
            y_reg  = gold_y_next(y_reg);
            xs_reg = gold_x_next(xs_reg);
            ys_reg = gold_y_next(ys_reg);
        end
        if (frame_end) begin
            frame_pos = '0;
            frame_count++;
        end else if (frame_pos != POS_MAX) begin
            frame_pos++;
        end
        descrambled_q.push_back(w);
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(7))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Mostly frames with a scrambled tail, some ending near the header edge
    // and some shorter than the header.
    function automatic int pick_frame_len();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return $urandom_range(1, 10);
        else if (r < 30)
            return $urandom_range(85, 95);
        return $urandom_range(96, 170);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s, expected %h, got %h", $time, what, want, got);
        fail_count++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_SCRAMBLER_SEQ) begin
            load_seeds(val);
        end else begin
            vl_mode = val[0];
        end
        @(posedge aclk);
    endtask

    // Called at a rising edge; returns at the edge where the word was taken.
    // s_tready is looked at on the falling edge, where it is settled.
    task automatic send_symbol(input sample_t si, input sample_t sq, input logic frame_end);
        if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sq, si};
        s_tlast  <= frame_end;
        forever begin
            @(negedge aclk);
            if (s_tready)
                break;
            @(posedge aclk);
        end
        @(posedge aclk);
        predict_symbol(si, sq, frame_end);
    endtask

    task automatic send_frame(input int len, input logic close);
        int k;
        for (k = 0; k < len; k++)
            send_symbol(rand_sample(), rand_sample(), close && (k == len - 1));
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (descrambled_q.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic test_directed_extremes;
        int a;
        int b;
        send_symbol(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        send_symbol(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_symbol(sample_t'(0), sample_t'(-1), 1'b0);
        send_symbol(sample_t'(-1), sample_t'(0), 1'b1);
        // A full header, then every pairing of the edge values in the
        // scrambled part so that the minimum gets negated.
        send_frame(int'(HDR_NORMAL), 1'b0);
        for (a = 0; a < 4; a++)
            for (b = 0; b < 4; b++)
                send_symbol(EDGE_VALS[a], EDGE_VALS[b], (a == 3) && (b == 3));
        drain_results();
    endtask

    task automatic test_random_frames(input int n);
        int f;
        for (f = 0; f < n; f++)
            send_frame(pick_frame_len(), 1'b1);
        drain_results();
    endtask

    // Switching to the long header inside the scrambled part puts the rest
    // of the frame back into the header region.
    task automatic test_header_switch_midframe;
        send_frame(120, 1'b0);
        drain_results();
        write_reg(REG_VL_SNR_MODE, 5'd1);
        send_frame(40, 1'b1);
        drain_results();
    endtask

    // A frame that runs into its scrambled part, then a sequence change
    // inside it: the running generators must keep their old code until the
    // frame ends.
    task automatic test_reseed_midframe;
        gaps_on = 1'b0;
        write_reg(REG_VL_SNR_MODE, 5'd0);
        send_frame(100, 1'b0);
        drain_results();
        write_reg(REG_SCRAMBLER_SEQ, SEQ_BEYOND);
        send_frame(20, 1'b1);
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_sequence_change(input logic [CFG_DATA_W-1:0] seq, input int n);
        write_reg(REG_SCRAMBLER_SEQ, seq);
        test_random_frames(n);
    endtask

    always @(posedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin : check_words
        symbol_t want;
        if (aresetn && m_tvalid && m_tready) begin
            word_count++;
            if (descrambled_q.size() == 0) begin
                report_mismatch("unexpected word", 32'd0, m_tdata);
            end else begin
                want = descrambled_q.pop_front();
                if (m_tdata[SW-1:0] !== want.i_val)
                    report_mismatch("out_i", 32'(want.i_val), 32'(m_tdata[SW-1:0]));
                if (m_tdata[2*SW-1:SW] !== want.q_val)
                    report_mismatch("out_q", 32'(want.q_val), 32'(m_tdata[2*SW-1:SW]));
                if (m_tlast !== want.frame_end)
                    report_mismatch("out_frame_end", 32'(want.frame_end), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words outstanding.",
                     cycle_count, descrambled_q.size());
            $display("pl_gold_descrambler_top_test NOT OK");
            $finish;
        end
    end

    initial begin : run_tests
        lfsr_t r;
        int    k;
        r = LFSR_ONES;
        for (k = 0; k < int'(SHIFT_OFFSET); k++)
            r = gold_y_next(r);
        ys_seed_r = r;
        vl_mode   = 1'b0;
        frame_pos = '0;
        load_seeds(SEQ_FIRST);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_extremes();
        test_random_frames(2);
        test_header_switch_midframe();
        test_reseed_midframe();
        test_random_frames(1);
        test_sequence_change(SEQ_MID, 1);

        drain_results();
        repeat (8) @(posedge aclk);
        $display("Checked %0d words in %0d frames; quarter turns 0/1/2/3 seen %0d/%0d/%0d/%0d.",
                 word_count, frame_count, rot_seen[0], rot_seen[1], rot_seen[2], rot_seen[3]);
        $display("Sequences 0, 31 and 5 with both header lengths; %0d mismatches.", fail_count);
        if (fail_count == 0) begin
            $display("pl_gold_descrambler_top_test OK");
        end else begin
            $display("pl_gold_descrambler_top_test NOT OK");
        end
        $finish;
    end

endmodule
